// ----- src/crls_pkg.sv -----
// Shared types and widths for the Catmull-Rom lane sampler.
package crls_pkg;

  localparam int COORD_W = 32;
  localparam int CNT_W   = 7;            // sample count, up to 64
  localparam int D2_W    = 2 * CNT_W;    // d^2
  localparam int DD_W    = 3 * CNT_W;    // d^3
  localparam int M_W     = DD_W + 1;     // divisor 2*d^3
  localparam int A_W     = 36;           // spline coefficients
  localparam int NW      = 58;           // numerator and forward differences
  localparam int Q_W     = 32;           // quotient bits

  localparam logic [COORD_W-1:0] SAT_MAX = 32'h7fff_ffff;
  localparam logic [COORD_W-1:0] SAT_MIN = 32'h8000_0000;

  typedef struct packed {
    logic load;
    logic coef;
    logic mul1;
    logic mul2;
    logic diff;
    logic prep;
    logic start;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic run_ok;
    logic div_busy;
    logic out_free;
    logic last;
  } sts_t;

endpackage

// ----- src/crls_div.sv -----
// Restoring divider: 32 quotient bits, one per cycle, with overflow flag.
module crls_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [crls_pkg::NW-1:0]   u,
  input  logic [crls_pkg::M_W-1:0]  m,
  output logic                      busy,
  output logic                      big,
  output logic [crls_pkg::Q_W-1:0]  q
);
  import crls_pkg::*;

  logic [M_W-1:0] r;
  logic [5:0]     cnt;
  logic [M_W:0]   trial;
  logic           ge;

  assign trial = {r, q[Q_W-1]};
  assign ge    = trial >= {1'b0, m};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 6'd1;
      if (cnt == 6'(Q_W - 1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      big <= u >= NW'({m, {Q_W{1'b0}}});
      r   <= u[Q_W +: M_W];
      q   <= u[Q_W-1:0];
    end else if (busy) begin
      r <= ge ? M_W'(trial - {1'b0, m}) : trial[M_W-1:0];
      q <= {q[Q_W-2:0], ge};
    end
  end

endmodule

// ----- src/crls_axis.sv -----
// One coordinate axis: coefficients, forward differences, rounding divide.
module crls_axis (
  input  logic                          clk,
  input  logic                          rst,
  input  crls_pkg::cmd_t                cmd,
  input  logic signed [crls_pkg::COORD_W-1:0] w0,
  input  logic signed [crls_pkg::COORD_W-1:0] w1,
  input  logic signed [crls_pkg::COORD_W-1:0] w2,
  input  logic signed [crls_pkg::COORD_W-1:0] cur,
  input  logic [crls_pkg::CNT_W-1:0]    d,
  input  logic [crls_pkg::D2_W-1:0]     d2,
  input  logic [crls_pkg::DD_W-1:0]     dd,
  input  logic [crls_pkg::M_W-1:0]      m,
  output logic                          busy,
  output logic [crls_pkg::COORD_W-1:0]  value
);
  import crls_pkg::*;

  logic signed [A_W-1:0] p0, p1, p2, p3;
  logic signed [A_W-1:0] a0, a1, a2, a3;
  logic signed [NW-1:0]  b0, b1, b2, b3;
  logic signed [NW-1:0]  num, e1, e2, e3;
  logic [NW-1:0]         u;
  logic                  neg;
  logic                  big;
  logic [Q_W-1:0]        q;

  logic signed [A_W+D2_W:0] prod1;
  logic signed [A_W+CNT_W:0] prod2;
  logic signed [A_W+DD_W:0]  prod0;

  assign prod1 = a1 * $signed({1'b0, d2});
  assign prod2 = a2 * $signed({1'b0, d});
  assign prod0 = a0 * $signed({1'b0, dd});

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      p0 <= A_W'(w0);
      p1 <= A_W'(w1);
      p2 <= A_W'(w2);
      p3 <= A_W'(cur);
    end
    if (cmd.coef) begin
      a0 <= p1 <<< 1;
      a1 <= p2 - p0;
      a2 <= (p0 <<< 1) - ((p1 <<< 2) + p1) + (p2 <<< 2) - p3;
      a3 <= ((p1 <<< 1) + p1) - ((p2 <<< 1) + p2) + p3 - p0;
    end
    if (cmd.mul1) begin
      b1 <= NW'(prod1);
      b2 <= NW'(prod2);
      b3 <= NW'(a3);
    end
    if (cmd.mul2) b0 <= NW'(prod0);
    if (cmd.diff) begin
      num <= b0 + $signed(NW'(dd));   // rounding bias folded in
      e1  <= b1 + b2 + b3;
      e2  <= (b2 <<< 1) + (b3 <<< 2) + (b3 <<< 1);
      e3  <= (b3 <<< 2) + (b3 <<< 1);
    end else if (cmd.emit) begin
      num <= num + e1;
      e1  <= e1 + e2;
      e2  <= e2 + e3;
    end
    if (cmd.prep) begin
      neg <= num[NW-1];
      // floor of a negative quotient through the ceiling of its magnitude
      u   <= num[NW-1] ? NW'(NW'(-num) + NW'(m) - NW'(1)) : num;
    end
  end

  crls_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.start),
    .u    (u),
    .m    (m),
    .busy (busy),
    .big  (big),
    .q    (q)
  );

  always_comb begin
    if (big) value = neg ? SAT_MIN : SAT_MAX;
    else if (!neg) value = q[Q_W-1] ? SAT_MAX : q;
    else if (q > SAT_MIN) value = SAT_MIN;
    else value = Q_W'(-q);
  end

endmodule

// ----- src/crls_dp.sv -----
// Datapath: point window, run count, two axis units and the output register.
module crls_dp #(
  parameter int MAX_SAMPLES = 64,
  parameter int FRAC_BITS   = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  crls_pkg::cmd_t                 cmd,
  output crls_pkg::sts_t                 sts,
  input  logic [2*crls_pkg::COORD_W-1:0] in_data,
  input  logic                           in_end,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [2*crls_pkg::COORD_W-1:0] out_data,
  output logic                           out_last,
  output logic                           out_clip
);
  import crls_pkg::*;

  logic signed [COORD_W-1:0] win_x [3];
  logic signed [COORD_W-1:0] win_y [3];
  logic [1:0]                held;
  logic signed [COORD_W-1:0] cur_x, cur_y;

  logic [CNT_W-1:0] n, idx, d, d_sel;
  logic             clip, run_ok;
  logic [D2_W-1:0]  d2;
  logic [DD_W-1:0]  dd;
  logic [M_W-1:0]   m;

  logic signed [COORD_W:0] span;
  logic [COORD_W:0]        n_raw;
  logic                    n_over;

  logic             busy_x, busy_y, last;
  logic [COORD_W-1:0] val_x, val_y;

  assign cur_x  = in_data[COORD_W-1:0];
  assign cur_y  = in_data[2*COORD_W-1:COORD_W];
  assign span   = (COORD_W+1)'(win_x[2]) - (COORD_W+1)'(win_x[1]);
  assign n_raw  = span[COORD_W] ? '0 : ((COORD_W+1)'(span) >> FRAC_BITS);
  assign n_over = n_raw > (COORD_W+1)'(MAX_SAMPLES);
  assign last   = idx == n - CNT_W'(1);
  assign d_sel  = (n > CNT_W'(1)) ? n - CNT_W'(1) : CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
      for (int k = 0; k < 3; k++) begin
        win_x[k] <= '0;
        win_y[k] <= '0;
      end
      run_ok <= 1'b0;
    end else if (cmd.load) begin
      run_ok <= (held == 2'd3) && (n_raw != '0);
      if (in_end) begin
        held <= '0;
        for (int k = 0; k < 3; k++) begin
          win_x[k] <= '0;
          win_y[k] <= '0;
        end
      end else if (held == 2'd3) begin
        win_x[0] <= win_x[1];
        win_y[0] <= win_y[1];
        win_x[1] <= win_x[2];
        win_y[1] <= win_y[2];
        win_x[2] <= cur_x;
        win_y[2] <= cur_y;
      end else begin
        win_x[held] <= cur_x;
        win_y[held] <= cur_y;
        held        <= held + 2'd1;
      end
    end
  end

  // d and d2 are ready at mul1, dd and m at mul2
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      clip <= n_over;
      n    <= n_over ? CNT_W'(MAX_SAMPLES) : n_raw[CNT_W-1:0];
    end
    if (cmd.coef) begin
      d  <= d_sel;
      d2 <= D2_W'(d_sel) * D2_W'(d_sel);
    end
    if (cmd.mul1) begin
      dd <= DD_W'(d2) * DD_W'(d);
      m  <= (M_W'(d2) * M_W'(d)) << 1;
    end
    if (cmd.diff) idx <= '0;
    else if (cmd.emit) idx <= idx + CNT_W'(1);
  end

  crls_axis u_ax_x (
    .clk(clk), .rst(rst), .cmd(cmd),
    .w0(win_x[0]), .w1(win_x[1]), .w2(win_x[2]), .cur(cur_x),
    .d(d), .d2(d2), .dd(dd), .m(m), .busy(busy_x), .value(val_x)
  );

  crls_axis u_ax_y (
    .clk(clk), .rst(rst), .cmd(cmd),
    .w0(win_y[0]), .w1(win_y[1]), .w2(win_y[2]), .cur(cur_y),
    .d(d), .d2(d2), .dd(dd), .m(m), .busy(busy_y), .value(val_y)
  );

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.emit) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data <= {val_y, val_x};
      out_last <= last;
      out_clip <= last && clip;
    end
  end

  assign sts.run_ok   = run_ok;
  assign sts.div_busy = busy_x | busy_y;
  assign sts.out_free = !out_valid || out_ready;
  assign sts.last     = last;

endmodule

// ----- src/crls_ctrl.sv -----
// Sequencer for setup, per-sample divide and result hand-off.
module crls_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  crls_pkg::sts_t sts,
  output crls_pkg::cmd_t cmd
);
  import crls_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_COEF = 9'b000000010,
    S_MUL1 = 9'b000000100,
    S_MUL2 = 9'b000001000,
    S_DIFF = 9'b000010000,
    S_PREP = 9'b000100000,
    S_STRT = 9'b001000000,
    S_DIV  = 9'b010000000,
    S_EMIT = 9'b100000000
  } state_t;

  state_t state, state_next;

  assign in_ready = state == S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_COEF;
        end
      end
      S_COEF: begin
        if (sts.run_ok) begin
          cmd.coef   = 1'b1;
          state_next = S_MUL1;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = S_DIFF;
      end
      S_DIFF: begin
        cmd.diff   = 1'b1;
        state_next = S_PREP;
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = S_STRT;
      end
      S_STRT: begin
        cmd.start  = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (!sts.div_busy) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = sts.last ? S_IDLE : S_PREP;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- src/catmull_rom_lane_sampler_top.sv -----
// Catmull-Rom lane sampler, top level.
// Each accepted point completes a window of four once three points are held and yields
// n = floor(x2 - x1) spline samples (capped at MAX_SAMPLES) between the middle two points.
// A point that yields no sample goes back to idle after its check; otherwise setup runs
// COEF, MUL1, MUL2 and DIFF, and each sample runs PREP, STRT, DIV and EMIT, paced by
// the restoring divides that the x and y units run side by side. The next point is
// accepted as soon as the last sample has entered the output register.
module catmull_rom_lane_sampler_top #(
  parameter int MAX_SAMPLES = 64,
  parameter int FRAC_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // point_x, point_y
  input  logic        s_tlast,   // lane_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // sample_x, sample_y
  output logic        m_tlast,   // run_last
  output logic        m_tuser    // clipped
);
  import crls_pkg::*;

  cmd_t cmd;
  sts_t sts;

  crls_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  crls_dp #(
    .MAX_SAMPLES(MAX_SAMPLES),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .in_data  (s_tdata),
    .in_end   (s_tlast),
    .out_ready(m_tready),
    .out_valid(m_tvalid),
    .out_data (m_tdata),
    .out_last (m_tlast),
    .out_clip (m_tuser)
  );

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for the Catmull-Rom lane sampler: directed and random lanes.
module tb_top;
  import crls_pkg::*;

  localparam int MAX_N  = 64;
  localparam int FRAC   = 16;
  localparam int UNIT   = 1 << FRAC;
  localparam int PERIOD = 12;

  typedef struct {
    logic [31:0] sx;
    logic [31:0] sy;
    logic        run_last;
    logic        clipped;
  } sample_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;   // point_x, point_y
  logic        s_tlast;   // lane_end
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;   // sample_x, sample_y
  logic        m_tlast;   // run_last
  logic        m_tuser;   // clipped

  sample_t   samples_due[$];
  int        fail_cnt;
  int        send_idle_pct;
  int        recv_stall_pct;
  longint    win_x[3];
  longint    win_y[3];
  int        held;

  catmull_rom_lane_sampler_top #(.MAX_SAMPLES(MAX_N), .FRAC_BITS(FRAC)) i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #(PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(PERIOD * 8_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    fail_cnt++;
  endtask

  // exact spline sum over 2*d^3, rounded half up, saturated to 32 bits
  function automatic logic [31:0] spline_axis(longint p0, longint p1, longint p2,
                                              longint p3, longint i, longint d);
    longint c0, c1, c2, c3, dd, num, den, q;
    c0  = 2 * p1;
    c1  = p2 - p0;
    c2  = 2 * p0 - 5 * p1 + 4 * p2 - p3;
    c3  = -p0 + 3 * p1 - 3 * p2 + p3;
    dd  = d * d * d;
    num = c0 * dd + c1 * i * d * d + c2 * i * i * d + c3 * i * i * i + dd;
    den = 2 * dd;
    q   = num / den;
    if ((num % den) != 0 && num < 0) q--;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q[31:0];
  endfunction

  task automatic predict_point(logic [31:0] px, logic [31:0] py, logic lane_end);
    longint  cx, cy, diff, n, d;
    logic    clip;
    sample_t s;
    cx = longint'(signed'(px));
    cy = longint'(signed'(py));
    if (held == 3) begin
      diff = win_x[2] - win_x[1];
      n    = (diff > 0) ? (diff >> FRAC) : 0;
      clip = n > MAX_N;
      if (clip) n = MAX_N;
      d = (n > 1) ? n - 1 : 1;
      for (longint i = 0; i < n; i++) begin
        s.sx       = spline_axis(win_x[0], win_x[1], win_x[2], cx, i, d);
        s.sy       = spline_axis(win_y[0], win_y[1], win_y[2], cy, i, d);
        s.run_last = (i == n - 1);
        s.clipped  = (i == n - 1) && clip;
        samples_due = {samples_due, s};
      end
      win_x[0] = win_x[1]; win_y[0] = win_y[1];
      win_x[1] = win_x[2]; win_y[1] = win_y[2];
      win_x[2] = cx;       win_y[2] = cy;
    end else begin
      win_x[held] = cx;
      win_y[held] = cy;
      held++;
    end
    if (lane_end) begin
      win_x = '{0, 0, 0};
      win_y = '{0, 0, 0};
      held  = 0;
    end
  endtask

  // valid stays high between back-to-back items; lowered only for a gap
  task automatic send_point(logic [31:0] px, logic [31:0] py, logic lane_end);
    int gap;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {py, px};
    s_tlast  <= lane_end;
    do @(posedge clk); while (!s_tready);
    predict_point(px, py, lane_end);
  endtask

  always @(posedge clk) begin
    sample_t w;
    if (m_tvalid && m_tready) begin
      if (samples_due.size() == 0) begin
        report_mismatch("unexpected sample", m_tdata[31:0], 32'h0);
      end else begin
        w = samples_due.pop_front();
        if (m_tdata[31:0] !== w.sx) report_mismatch("sample_x", m_tdata[31:0], w.sx);
        if (m_tdata[63:32] !== w.sy) report_mismatch("sample_y", m_tdata[63:32], w.sy);
        if (m_tlast !== w.run_last)
          report_mismatch("run_last", 32'(m_tlast), 32'(w.run_last));
        if (m_tuser !== w.clipped)
          report_mismatch("clipped", 32'(m_tuser), 32'(w.clipped));
      end
    end
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  task automatic test_directed();
    set_idling(0, 0);
    // short lane: fewer than four points, no samples
    send_point(32'h0001_0000, 32'h0000_0000, 1'b1);
    send_point(32'h0000_0000, 32'h0000_0000, 1'b0);
    send_point(32'h0001_0000, 32'h0001_0000, 1'b0);
    send_point(32'h0002_0000, 32'h0002_0000, 1'b0);
    // x2 - x1 exactly one unit: single sample at p1
    send_point(32'h0003_0000, 32'h0003_0000, 1'b0);
    // just below one unit, then negative
    send_point(32'h0003_ffff, 32'h0000_8000, 1'b0);
    send_point(32'h0001_0000, 32'hffff_0000, 1'b0);
    send_point(32'h0005_0000, 32'h0002_0000, 1'b0);
    // exactly MAX samples, then one over (clipped)
    send_point(32'h0045_0000, 32'h0004_0000, 1'b0);
    send_point(32'h0086_0000, 32'h0001_0000, 1'b0);
    send_point(32'h00c0_0000, 32'h0008_0000, 1'b1);
    // y overshoots past the upper rail: saturation
    send_point(32'h0000_0000, 32'h8000_0000, 1'b0);
    send_point(32'h0000_0000, 32'h7fff_ffff, 1'b0);
    send_point(32'h0008_0000, 32'h7fff_ffff, 1'b0);
    send_point(32'h0010_0000, 32'h8000_0000, 1'b0);
    send_point(32'h0018_0000, 32'h7fff_ffff, 1'b1);
    // coordinate extremes: huge span clipped
    send_point(32'h8000_0000, 32'h8000_0000, 1'b0);
    send_point(32'h8000_0000, 32'h7fff_ffff, 1'b0);
    send_point(32'h7fff_ffff, 32'h8000_0000, 1'b0);
    send_point(32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
    send_point(32'h8000_0000, 32'h0000_0000, 1'b1);
  endtask

  task automatic test_random_lanes(int items, int send_pct, int recv_pct);
    int          sent, len, r;
    logic [31:0] px, py;
    set_idling(send_pct, recv_pct);
    sent = 0;
    while (sent < items) begin
      len = $urandom_range(2, 12);
      px  = $urandom;
      py  = $urandom;
      for (int k = 0; k < len && sent < items; k++) begin
        r = $urandom_range(99);
        if (r < 60)      px = px + $urandom_range(0, 7) * UNIT + $urandom_range(0, UNIT - 1);
        else if (r < 80) px = px + $urandom_range(8, 20) * UNIT + $urandom_range(0, UNIT - 1);
        else if (r < 84) px = px + $urandom_range(60, 70) * UNIT;
        else if (r < 95) px = px - $urandom_range(0, 3 * UNIT);
        else             px = $urandom;
        py = (r >= 97) ? $urandom : py + $urandom_range(0, 8 * UNIT) - 4 * UNIT;
        send_point(px, py, (k == len - 1) || ($urandom_range(99) < 2));
        sent++;
      end
    end
  endtask

  initial begin
    fail_cnt = 0;
    held     = 0;
    win_x    = '{0, 0, 0};
    win_y    = '{0, 0, 0};
    set_idling(0, 0);
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tlast  <= 1'b0;
    m_tready <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_lanes(90, 0, 0);
    test_random_lanes(85, 64, 0);
    test_random_lanes(85, 0, 64);
    test_random_lanes(85, 18, 18);
    s_tvalid <= 1'b0;
    while (samples_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_cnt == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
